// ===== hdl/spsm_pkg.sv =====
`default_nettype none
package spsm_pkg;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;
	localparam logic signed [63:0] Q_ONE = 64'sd268435456;
	localparam logic signed [31:0] ONE30 = 32'sd1073741824;
	localparam logic signed [35:0] HALF_PI30 = 36'sd1686629713;
	localparam logic signed [35:0] QUART_PI30 = 36'sd843314857;

	// horner divisors k(k+1), outermost term first
	localparam int unsigned COS_DIV [5] = '{90, 56, 30, 12, 2};
	localparam int unsigned SIN_DIV [5] = '{110, 72, 42, 20, 6};

	// configuration register indexes
	localparam logic [1:0] REG_KS = 2'd0;
	localparam logic [1:0] REG_RK = 2'd1;
	localparam logic [1:0] REG_IRK = 2'd2;
	localparam logic [1:0] REG_LEN = 2'd3;

	typedef struct packed {
		logic signed [31:0] dl;
		logic signed [31:0] py;
		logic signed [31:0] px;
		logic signed [31:0] z;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} coord_t;

	typedef struct packed {
		coord_t crd;
		logic signed [31:0] e;
		logic signed [31:0] pxys;
		logic lost;
	} sq_side_t;

	typedef struct packed {
		coord_t crd;
		logic lost;
		logic pz_zero;
	} dv_side_t;

	typedef struct packed {
		logic den_zero;
		logic den_neg;
		logic num_nz;
	} pd_side_t;

	typedef struct packed {
		coord_t crd;
		logic lost;
		logic signed [31:0] q;
	} sc_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return S32_MAX;
		if (v < -64'sd2147483648) return S32_MIN;
		return v[31:0];
	endfunction

	// add half, floor shift
	function automatic logic signed [63:0] rnd(input logic signed [63:0] p,
		input int unsigned sh);
		return (p + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	// signed saturation of a quotient magnitude
	function automatic logic signed [31:0] sat_quo(input logic [59:0] mag, input logic neg);
		logic [59:0] nm;
		nm = ~mag + 60'd1;
		if (!neg) begin
			if (mag > 60'd2147483647) return S32_MAX;
			return mag[31:0];
		end
		if (mag > 60'd2147483648) return S32_MIN;
		return nm[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/spsm_sqrt.sv =====
`default_nettype none
module spsm_sqrt #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [63:0]   radicand,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [31:0]   root,
	output logic [SW-1:0] side_out
);
	localparam int NS = 32;

	logic [63:0]   rem_s [1:NS];
	logic [63:0]   res_s [1:NS];
	logic [SW-1:0] sd_s  [1:NS];
	logic          vl_s  [1:NS];

	for (genvar i = 0; i < NS; i++) begin : g_st
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0]   v_in, r_in, sum;
		logic [SW-1:0] s_in;
		logic          vi, ge;
		if (i == 0) begin : g_first
			assign v_in = radicand;
			assign r_in = 64'd0;
			assign s_in = side_in;
			assign vi = in_valid;
		end else begin : g_next
			assign v_in = rem_s[i];
			assign r_in = res_s[i];
			assign s_in = sd_s[i];
			assign vi = vl_s[i];
		end
		assign sum = r_in + BIT;
		assign ge = v_in >= sum;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vl_s[i+1] <= 1'b0;
			else if (en) vl_s[i+1] <= vi;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? v_in - sum : v_in;
				res_s[i+1] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
				sd_s[i+1] <= s_in;
			end
		end
	end

	assign out_valid = vl_s[NS];
	assign root = res_s[NS][31:0];
	assign side_out = sd_s[NS];

endmodule
`default_nettype wire

// ===== hdl/spsm_div.sv =====
`default_nettype none
module spsm_div #(
	parameter int NW = 60,
	parameter int DW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	// restoring division, one quotient bit per stage
	logic [DW-1:0] rem_s [1:NW];
	logic [NW-1:0] nrm_s [1:NW];
	logic [NW-1:0] quo_s [1:NW];
	logic [DW-1:0] den_s [1:NW];
	logic [SW-1:0] sd_s  [1:NW];
	logic          vl_s  [1:NW];

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW-1:0] r_in, d_in;
		logic [NW-1:0] n_in, q_in;
		logic [SW-1:0] s_in;
		logic          vi, ge;
		logic [DW:0]   trial, diff;
		if (i == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num;
			assign q_in = '0;
			assign d_in = den;
			assign s_in = side_in;
			assign vi = in_valid;
		end else begin : g_next
			assign r_in = rem_s[i];
			assign n_in = nrm_s[i];
			assign q_in = quo_s[i];
			assign d_in = den_s[i];
			assign s_in = sd_s[i];
			assign vi = vl_s[i];
		end
		assign trial = {r_in, n_in[NW-1]};
		assign ge = trial >= {1'b0, d_in};
		assign diff = trial - {1'b0, d_in};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vl_s[i+1] <= 1'b0;
			else if (en) vl_s[i+1] <= vi;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				nrm_s[i+1] <= n_in << 1;
				quo_s[i+1] <= {q_in[NW-2:0], ge};
				den_s[i+1] <= d_in;
				sd_s[i+1] <= s_in;
			end
		end
	end

	assign out_valid = vl_s[NW];
	assign quo = quo_s[NW];
	assign side_out = sd_s[NW];

endmodule
`default_nettype wire

// ===== hdl/spsm_sincos.sv =====
`default_nettype none
module spsm_sincos #(
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic signed [31:0] ang,
	input  logic [SW-1:0]     side_in,
	output logic              out_valid,
	output logic signed [31:0] sin_o,
	output logic signed [31:0] cos_o,
	output logic [SW-1:0]     side_out
);
	import spsm_pkg::*;

	localparam int HS = 5;
	localparam int HL = 2 * HS;
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic [SW-1:0]     side;
		logic signed [31:0] r;
		logic [3:0]        n;
		logic signed [31:0] r2;
	} hb_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [35:0] a_s1;
	logic [3:0] n_s1, n_s2, n_s3;
	logic [SW-1:0] sd_s1, sd_s2, sd_s3;
	logic signed [31:0] r_s2, r_s3;
	logic signed [63:0] rr_s3;
	hb_t hb_s4, hb_s5, hb_s6;
	logic signed [63:0] sr_s5;
	logic signed [31:0] hc_s5;

	// quadrant count: n = floor((4*ang + pi/4) / (pi/2)), n in -5..5
	logic signed [35:0] a_c, num_c;
	logic [3:0] n_c;
	always_comb begin
		logic [3:0] cnt;
		cnt = 4'd0;
		a_c = {ang[31], ang[31], ang, 2'b00};
		num_c = a_c + QUART_PI30;
		for (int k = -4; k <= 5; k++) begin
			if (num_c >= 36'(k) * HALF_PI30) cnt = cnt + 4'd1;
		end
		n_c = cnt - 4'd5;
	end

	logic signed [35:0] r_full;
	assign r_full = a_s1 - $signed({{32{n_s1[3]}}, n_s1}) * HALF_PI30;

	logic signed [63:0] r2_full;
	assign r2_full = rnd(rr_s3, 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_c;
			n_s1 <= n_c;
			sd_s1 <= side_in;
			r_s2 <= r_full[31:0];
			n_s2 <= n_s1;
			sd_s2 <= sd_s1;
			rr_s3 <= r_s2 * r_s2;
			r_s3 <= r_s2;
			n_s3 <= n_s2;
			sd_s3 <= sd_s2;
			hb_s4.side <= sd_s3;
			hb_s4.r <= r_s3;
			hb_s4.n <= n_s3;
			hb_s4.r2 <= r2_full[31:0];
		end
	end

	// horner chains, two stages per term: product, then divide by k(k+1)
	hb_t hb_s [1:HL];
	logic hv_s [1:HL];
	logic signed [63:0] hpc_s [HS];
	logic signed [63:0] hps_s [HS];
	logic [62:0] hmc_s [HS];
	logic [62:0] hms_s [HS];
	logic signed [31:0] hnc [HS];
	logic signed [31:0] hns [HS];

	for (genvar j = 0; j < HS; j++) begin : g_h
		localparam int DC = COS_DIV[j];
		localparam int DS = SIN_DIV[j];
		localparam int SC = 31 + $clog2(DC);
		localparam int SS = 31 + $clog2(DS);
		localparam logic [63:0] MC = ((64'd1 << SC) + 64'(DC) - 64'd1) / 64'(DC);
		localparam logic [63:0] MS = ((64'd1 << SS) + 64'(DS) - 64'd1) / 64'(DS);
		hb_t b_a;
		logic va;
		logic signed [31:0] hc_in, hs_in;
		logic signed [63:0] mc_full, ms_full;
		logic [62:0] qc_w, qs_w;
		if (j == 0) begin : g_first
			assign b_a = hb_s4;
			assign va = v_s4;
			assign hc_in = ONE30;
			assign hs_in = ONE30;
		end else begin : g_next
			assign b_a = hb_s[2*j];
			assign va = hv_s[2*j];
			assign hc_in = hnc[j-1];
			assign hs_in = hns[j-1];
		end
		assign mc_full = rnd(hpc_s[j], 30);
		assign ms_full = rnd(hps_s[j], 30);
		assign qc_w = hmc_s[j] >> SC;
		assign qs_w = hms_s[j] >> SS;
		assign hnc[j] = ONE30 - $signed({1'b0, qc_w[30:0]});
		assign hns[j] = ONE30 - $signed({1'b0, qs_w[30:0]});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[2*j+1] <= 1'b0;
				hv_s[2*j+2] <= 1'b0;
			end else if (en) begin
				hv_s[2*j+1] <= va;
				hv_s[2*j+2] <= hv_s[2*j+1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				hb_s[2*j+1] <= b_a;
				hpc_s[j] <= b_a.r2 * hc_in;
				hps_s[j] <= b_a.r2 * hs_in;
				hb_s[2*j+2] <= hb_s[2*j+1];
				hmc_s[j] <= mc_full[30:0] * MC[31:0];
				hms_s[j] <= ms_full[30:0] * MS[31:0];
			end
		end
	end

	// sine = r * h, then quadrant fold and round to q4.28
	logic signed [31:0] s30, so, co;
	logic signed [63:0] s30_full;
	assign s30_full = rnd(sr_s5, 30);
	assign s30 = s30_full[31:0];
	always_comb begin
		unique case (hb_s5.n[1:0])
			QUAD_0: begin so = s30; co = hc_s5; end
			QUAD_1: begin so = hc_s5; co = -s30; end
			QUAD_2: begin so = -s30; co = -hc_s5; end
			QUAD_3: begin so = -hc_s5; co = s30; end
			default: begin so = s30; co = hc_s5; end
		endcase
	end

	logic signed [63:0] so_r, co_r;
	assign so_r = rnd(64'(so), 2);
	assign co_r = rnd(64'(co), 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= hv_s[HL];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hb_s5 <= hb_s[HL];
			sr_s5 <= hb_s[HL].r * hns[HS-1];
			hc_s5 <= hnc[HS-1];
			hb_s6 <= hb_s5;
			sin_o <= so_r[31:0];
			cos_o <= co_r[31:0];
		end
	end

	assign out_valid = v_s6;
	assign side_out = hb_s6.side;

endmodule
`default_nettype wire

// ===== hdl/solenoid_phase_space_map_top.sv =====
`default_nettype none
// solenoid phase-space map, one particle word in, one word out
// pipeline sections in order: front, sqrt, denominator, divide, fold,
// sine/cosine, transfer map
// throughput: one word per cycle; the whole pipeline holds while the output waits
// reset: arst_n clears all valid bits and the four configuration registers
module solenoid_phase_space_map_top (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input particle: pos_x, pos_y, pos_z, mom_x, mom_y, energy_dev (32 each)
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,
	// output particle: out_pos_x, out_pos_y, out_pos_z, out_mom_x, out_mom_y,
	// out_energy_dev (32 each)
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,
	// lost
	output logic [0:0]   m_tuser
);
	import spsm_pkg::*;

	localparam int NW = 60;
	localparam int DW1 = 31;
	localparam int DW2 = 35;

	// configuration registers
	logic signed [31:0] ks_q, rk_q, irk_q;
	logic [30:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= '0;
			rk_q <= '0;
			irk_q <= '0;
			len_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_KS: ks_q <= cfg_data;
				REG_RK: rk_q <= cfg_data;
				REG_IRK: irk_q <= cfg_data;
				REG_LEN: len_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// one enable for every stage: advance unless the output word is stuck
	logic en;
	logic v_s12;
	assign en = !v_s12 || m_tready;
	assign s_tready = en;

	coord_t in_crd;
	assign in_crd = coord_t'(s_tdata);

	// front: kinetic momenta, squares, radicand
	logic v_s1, v_s2, v_s3, v_s4;
	coord_t crd_s1, crd_s2, crd_s3;
	logic signed [63:0] ry_s1, rx_s1;
	logic signed [31:0] e_s1, e_s2, e_s3;
	logic signed [31:0] vx_s2, vy_s2;
	logic signed [63:0] sxx_s3, syy_s3, see_s3;
	logic [63:0] rad_s4;
	sq_side_t sq_s4;

	logic signed [63:0] pxy2_c, rad_c;
	logic lost_c;
	assign pxy2_c = rnd(sxx_s3, 28) + rnd(syy_s3, 28);
	assign rad_c = rnd(see_s3, 28) - pxy2_c;
	assign lost_c = rad_c < 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s1 <= in_crd;
			ry_s1 <= rk_q * in_crd.y;
			rx_s1 <= rk_q * in_crd.x;
			e_s1 <= sat32(64'(in_crd.dl) + Q_ONE);
			crd_s2 <= crd_s1;
			e_s2 <= e_s1;
			vx_s2 <= sat32(64'(crd_s1.px) + rnd(ry_s1, 29));
			vy_s2 <= sat32(64'(crd_s1.py) - rnd(rx_s1, 29));
			crd_s3 <= crd_s2;
			e_s3 <= e_s2;
			sxx_s3 <= vx_s2 * vx_s2;
			syy_s3 <= vy_s2 * vy_s2;
			see_s3 <= e_s2 * e_s2;
			rad_s4 <= lost_c ? 64'd0 : 64'(rad_c) << 28;
			sq_s4.crd <= crd_s3;
			sq_s4.e <= e_s3;
			sq_s4.pxys <= sat32(pxy2_c);
			sq_s4.lost <= lost_c;
		end
	end

	// pz = floor(sqrt(rad * 2^28))
	logic sq_v;
	logic [31:0] sq_root;
	logic [$bits(sq_side_t)-1:0] sq_side_w;
	sq_side_t sq_o;

	spsm_sqrt #(.SW($bits(sq_side_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.radicand (rad_s4),
		.side_in  (sq_s4),
		.out_valid(sq_v),
		.root     (sq_root),
		.side_out (sq_side_w)
	);
	assign sq_o = sq_side_t'(sq_side_w);

	// path-term denominator pz * (pz + E)
	logic v_s5, v_s6, v_s7;
	logic signed [31:0] pz_s5, pze_s5, pz_s6, pz_s7;
	logic signed [63:0] pd_s6;
	logic signed [35:0] den_s7;
	sq_side_t sq_s5, sq_s6, sq_s7;

	logic signed [31:0] pz_c;
	logic signed [63:0] den_c;
	assign pz_c = (sq_root > 32'h7fffffff) ? S32_MAX : $signed(sq_root);
	assign den_c = rnd(pd_s6, 28);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= sq_v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pz_s5 <= pz_c;
			pze_s5 <= sat32(64'(pz_c) + 64'(sq_o.e));
			sq_s5 <= sq_o;
			pd_s6 <= pz_s5 * pze_s5;
			pz_s6 <= pz_s5;
			sq_s6 <= sq_s5;
			den_s7 <= den_c[35:0];
			pz_s7 <= pz_s6;
			sq_s7 <= sq_s6;
		end
	end

	// two dividers side by side: angle Ks/pz and path quotient
	logic [31:0] ks_mag;
	logic [35:0] den_mag;
	logic [NW-1:0] num1, num2, quo1, quo2;
	dv_side_t dv_in, dv_o;
	pd_side_t pd_in, pd_o;
	logic [$bits(dv_side_t)-1:0] dv_w;
	logic [$bits(pd_side_t)-1:0] pd_w;
	logic dv1_v, dv2_v;

	assign ks_mag = ks_q[31] ? ~ks_q + 32'd1 : ks_q;
	assign den_mag = den_s7[35] ? ~den_s7 + 36'd1 : den_s7;
	assign num1 = {ks_mag, 28'd0};
	assign num2 = {1'b0, sq_s7.pxys[30:0], 28'd0};
	assign dv_in.crd = sq_s7.crd;
	assign dv_in.lost = sq_s7.lost;
	assign dv_in.pz_zero = pz_s7 == 32'sd0;
	assign pd_in.den_zero = den_s7 == 36'sd0;
	assign pd_in.den_neg = den_s7[35];
	assign pd_in.num_nz = sq_s7.pxys != 32'sd0;

	spsm_div #(.NW(NW), .DW(DW1), .SW($bits(dv_side_t))) u_div_ang (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.num      (num1),
		.den      (pz_s7[DW1-1:0]),
		.side_in  (dv_in),
		.out_valid(dv1_v),
		.quo      (quo1),
		.side_out (dv_w)
	);

	spsm_div #(.NW(NW), .DW(DW2), .SW($bits(pd_side_t))) u_div_path (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.num      (num2),
		.den      (den_mag[DW2-1:0]),
		.side_in  (pd_in),
		.out_valid(dv2_v),
		.quo      (quo2),
		.side_out (pd_w)
	);
	assign dv_o = dv_side_t'(dv_w);
	assign pd_o = pd_side_t'(pd_w);

	// zero divisor cases, sign and saturation
	logic v_s8;
	logic signed [31:0] kpz_s8;
	sc_side_t sc_s8;
	logic signed [31:0] kpz_c, q_c;

	always_comb begin
		if (dv_o.pz_zero) begin
			if (ks_q > 32'sd0) kpz_c = S32_MAX;
			else if (ks_q < 32'sd0) kpz_c = S32_MIN;
			else kpz_c = 32'sd0;
		end else begin
			kpz_c = sat_quo(quo1, ks_q[31]);
		end
		if (pd_o.den_zero) q_c = pd_o.num_nz ? S32_MAX : 32'sd0;
		else q_c = sat_quo(quo2, pd_o.den_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= dv1_v & dv2_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kpz_s8 <= kpz_c;
			sc_s8.crd <= dv_o.crd;
			sc_s8.lost <= dv_o.lost;
			sc_s8.q <= q_c;
		end
	end

	// sine and cosine of the rotation angle
	logic sc_v;
	logic signed [31:0] sn, cs;
	logic [$bits(sc_side_t)-1:0] sc_w;
	sc_side_t sc_o;

	spsm_sincos #(.SW($bits(sc_side_t))) u_sincos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.ang      (kpz_s8),
		.side_in  (sc_s8),
		.out_valid(sc_v),
		.sin_o    (sn),
		.cos_o    (cs),
		.side_out (sc_w)
	);
	assign sc_o = sc_side_t'(sc_w);

	// matrix coefficients
	logic v_s9, v_s10, v_s11;
	sc_side_t sc_s9, sc_s10, sc_s11;
	logic signed [63:0] rs_s9, romc_s9, si_s9, oi_s9;
	logic signed [31:0] t11_s9, t31_s9;
	logic signed [31:0] t11_s10, t21_s10, t31_s10, t41_s10, t12_s10, t32_s10;
	logic signed [63:0] pr_s11 [16];
	logic signed [63:0] ql_s11;
	logic signed [31:0] omc_c;

	assign omc_c = 32'sd268435456 - cs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s9 <= sc_v;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s9 <= sc_o;
			rs_s9 <= rk_q * sn;
			romc_s9 <= rk_q * omc_c;
			si_s9 <= sn * irk_q;
			oi_s9 <= omc_c * irk_q;
			t11_s9 <= sat32((64'(cs) + Q_ONE) >>> 1);
			t31_s9 <= sat32(-(64'(sn) >>> 1));
			sc_s10 <= sc_s9;
			t11_s10 <= t11_s9;
			t31_s10 <= t31_s9;
			t21_s10 <= sat32(-rnd(rs_s9, 30));
			t41_s10 <= sat32(rnd(romc_s9, 30));
			t12_s10 <= sat32(rnd(si_s9, 28));
			t32_s10 <= sat32(-rnd(oi_s9, 28));
			// transfer map products, four per coordinate
			sc_s11 <= sc_s10;
			pr_s11[0] <= t11_s10 * sc_s10.crd.x;
			pr_s11[1] <= t12_s10 * sc_s10.crd.px;
			pr_s11[2] <= t31_s10 * sc_s10.crd.y;
			pr_s11[3] <= t32_s10 * sc_s10.crd.py;
			pr_s11[4] <= t21_s10 * sc_s10.crd.x;
			pr_s11[5] <= t11_s10 * sc_s10.crd.px;
			pr_s11[6] <= t41_s10 * sc_s10.crd.y;
			pr_s11[7] <= t31_s10 * sc_s10.crd.py;
			pr_s11[8] <= t31_s10 * sc_s10.crd.x;
			pr_s11[9] <= t32_s10 * sc_s10.crd.px;
			pr_s11[10] <= t11_s10 * sc_s10.crd.y;
			pr_s11[11] <= t12_s10 * sc_s10.crd.py;
			pr_s11[12] <= t41_s10 * sc_s10.crd.x;
			pr_s11[13] <= t31_s10 * sc_s10.crd.px;
			pr_s11[14] <= t21_s10 * sc_s10.crd.y;
			pr_s11[15] <= t11_s10 * sc_s10.crd.py;
			ql_s11 <= sc_s10.q * $signed({1'b0, len_q});
		end
	end

	// sums, saturation, lost particle pass-through
	coord_t o_crd_s12, map_c;
	logic lost_s12;

	always_comb begin
		map_c.x = sat32(rnd(pr_s11[0], 28) + rnd(pr_s11[1], 28)
			- rnd(pr_s11[2], 28) - rnd(pr_s11[3], 28));
		map_c.px = sat32(rnd(pr_s11[4], 28) + rnd(pr_s11[5], 28)
			- rnd(pr_s11[6], 28) - rnd(pr_s11[7], 28));
		map_c.y = sat32(rnd(pr_s11[8], 28) + rnd(pr_s11[9], 28)
			+ rnd(pr_s11[10], 28) + rnd(pr_s11[11], 28));
		map_c.py = sat32(rnd(pr_s11[12], 28) + rnd(pr_s11[13], 28)
			+ rnd(pr_s11[14], 28) + rnd(pr_s11[15], 28));
		map_c.z = sat32(64'(sc_s11.crd.z) - rnd(ql_s11, 28));
		map_c.dl = sc_s11.crd.dl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_crd_s12 <= sc_s11.lost ? sc_s11.crd : map_c;
			lost_s12 <= sc_s11.lost;
		end
	end

	assign m_tvalid = v_s12;
	assign m_tdata = o_crd_s12;
	assign m_tuser = lost_s12;

endmodule
`default_nettype wire

// ===== tb/sv/solenoid_phase_space_map_top_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module solenoid_phase_space_map_top_test;
	import spsm_pkg::*;

	typedef struct {
		coord_t crd;
		logic   lost;
	} particle_t;

	// keeps the register copy, predicts each particle and checks results in order
	class solenoid_map_checker;
		longint ks, rk, irk, len;
		particle_t pending_particles [$];
		int errors;

		function new();
			ks = 0;
			rk = 0;
			irk = 0;
			len = 0;
			errors = 0;
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_KS: ks = longint'(signed'(val));
				REG_RK: rk = longint'(signed'(val));
				REG_IRK: irk = longint'(signed'(val));
				REG_LEN: len = longint'({1'b0, val[30:0]});
			endcase
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// rounded product, floor shift
		function longint mul_round(longint a, longint b, int sh);
			return (a * b + (longint'(1) <<< (sh - 1))) >>> sh;
		endfunction

		function longint quot(longint num, longint den);
			if (den == 0) begin
				if (num > 0) return 64'sd2147483647;
				if (num < 0) return -64'sd2147483648;
				return 0;
			end
			return sat((num * 64'sd268435456) / den);
		endfunction

		function longint root(bit [63:0] v);
			bit [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return longint'(res);
		endfunction

		// angle in Q4.28, reduced by quarter turns, horner in Q2.30
		function void sin_cos(longint ang, output longint sn, output longint cs);
			longint a, num, n, r, r2, hc, hs, s30, so, co, hp, qp;
			hp = longint'(HALF_PI30);
			qp = longint'(QUART_PI30);
			a = ang * 4;
			num = a + qp;
			n = (num >= 0) ? num / hp : -(((-num) + hp - 1) / hp);
			r = a - n * hp;
			r2 = mul_round(r, r, 30);
			hc = 64'sd1073741824;
			for (int k = 9; k >= 1; k -= 2)
				hc = 64'sd1073741824 - mul_round(r2, hc, 30) / longint'(k * (k + 1));
			hs = 64'sd1073741824;
			for (int k = 10; k >= 2; k -= 2)
				hs = 64'sd1073741824 - mul_round(r2, hs, 30) / longint'(k * (k + 1));
			s30 = mul_round(r, hs, 30);
			case (n[1:0])
				2'd0: begin so = s30; co = hc; end
				2'd1: begin so = hc; co = -s30; end
				2'd2: begin so = -s30; co = -hc; end
				default: begin so = -hc; co = s30; end
			endcase
			sn = (so + 2) >>> 2;
			cs = (co + 2) >>> 2;
		endfunction

		function particle_t transfer(coord_t p);
			particle_t o;
			longint x, y, z, px, py, e, vx, vy, perp2, rad, pz, kpz, s, c, omc;
			longint t11, t21, t31, t41, t12, t32, den, q;
			x = longint'(p.x); y = longint'(p.y); z = longint'(p.z);
			px = longint'(p.px); py = longint'(p.py);
			o.crd = p;
			e = sat(64'sd268435456 + longint'(p.dl));
			vx = sat(px + mul_round(rk, y, 29));
			vy = sat(py - mul_round(rk, x, 29));
			perp2 = mul_round(vx, vx, 28) + mul_round(vy, vy, 28);
			rad = mul_round(e, e, 28) - perp2;
			o.lost = (rad < 0);
			if (!o.lost) begin
				pz = sat(root(64'(rad) << 28));
				kpz = quot(ks, pz);
				sin_cos(kpz, s, c);
				omc = 64'sd268435456 - c;
				t11 = sat((64'sd268435456 + c) >>> 1);
				t21 = sat(-mul_round(rk, s, 30));
				t31 = sat(-(s >>> 1));
				t41 = sat(mul_round(rk, omc, 30));
				t12 = sat(mul_round(s, irk, 28));
				t32 = sat(-mul_round(omc, irk, 28));
				o.crd.x = 32'(sat(mul_round(t11, x, 28) + mul_round(t12, px, 28)
					- mul_round(t31, y, 28) - mul_round(t32, py, 28)));
				o.crd.px = 32'(sat(mul_round(t21, x, 28) + mul_round(t11, px, 28)
					- mul_round(t41, y, 28) - mul_round(t31, py, 28)));
				o.crd.y = 32'(sat(mul_round(t31, x, 28) + mul_round(t32, px, 28)
					+ mul_round(t11, y, 28) + mul_round(t12, py, 28)));
				o.crd.py = 32'(sat(mul_round(t41, x, 28) + mul_round(t31, px, 28)
					+ mul_round(t21, y, 28) + mul_round(t11, py, 28)));
				den = mul_round(pz, sat(pz + e), 28);
				q = quot(sat(perp2), den);
				o.crd.z = 32'(sat(z - mul_round(q, len, 28)));
			end
			return o;
		endfunction

		function void note_particle(coord_t p);
			pending_particles.push_back(transfer(p));
		endfunction

		function void check_particle(logic [191:0] data, logic lost_bit);
			particle_t want;
			logic [5:0][31:0] got, ref_w;
			string names [6];
			names = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_mom_x", "out_mom_y",
				"out_energy_dev"};
			if (pending_particles.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			want = pending_particles.pop_front();
			got = data;
			ref_w = want.crd;
			for (int i = 0; i < 6; i++)
				if (got[i] !== ref_w[i])
					report($sformatf("%s got %h want %h", names[i], got[i], ref_w[i]));
			if (lost_bit !== want.lost)
				report($sformatf("lost got %b want %b", lost_bit, want.lost));
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic [0:0]   m_tuser;

	solenoid_map_checker chk;
	bit no_idle;        // phase without gaps on either side
	bit hold_request;   // asks the receiver for one long hold-off

	solenoid_phase_space_map_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one register write per cycle; caller lowers cfg_wen after the last one
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		chk.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] ks, logic [31:0] rk, logic [31:0] irk,
		logic [31:0] len);
		write_reg(REG_KS, ks);
		write_reg(REG_RK, rk);
		write_reg(REG_IRK, irk);
		write_reg(REG_LEN, len);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_particle(coord_t p);
		int gap;
		s_tdata <= p;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		chk.note_particle(p);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender goes quiet until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk.pending_particles.size() > 0) @(posedge clk);
	endtask

	function automatic coord_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] px, logic [31:0] py, logic [31:0] dl);
		coord_t p;
		p.x = x; p.y = y; p.z = z; p.px = px; p.py = py; p.dl = dl;
		return p;
	endfunction

	function automatic logic [31:0] rnd_span(int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// mostly physical particles, some near the lost edge, some raw noise
	function automatic coord_t random_particle();
		coord_t p;
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			p.x = rnd_span(1 << 26);
			p.y = rnd_span(1 << 26);
			p.z = rnd_span(1 << 28);
			p.dl = rnd_span(1 << 25);
			if (r < 70) begin
				p.px = rnd_span(1 << 25);
				p.py = rnd_span(1 << 25);
			end else begin
				p.px = rnd_span(1 << 29);
				p.py = rnd_span(1 << 28);
				p.dl = rnd_span(1 << 29);
			end
		end
		return p;
	endfunction

	// receiver with random stalls and one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) chk.check_particle(m_tdata, m_tuser[0]);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 12) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#10ms;
		$display("solenoid_phase_space_map_top_test: FAIL");
		$finish;
	end

	initial begin
		logic [31:0] one, mx, mn;
		one = 32'h1000_0000;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;
		chk = new();
		no_idle = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unit strength, rk of one half, extremes and corner cases
		load_regs(one, 32'h0800_0000, 32'h2000_0000, 32'h1000_0000);
		send_particle(mk(0, 0, 0, 0, 0, 0));
		send_particle(mk(mx, mx, mx, mx, mx, mx));
		send_particle(mk(mn, mn, mn, mn, mn, mn));
		send_particle(mk(mx, mn, mx, mn, mx, mn));
		send_particle(mk(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555));
		send_particle(mk(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			32'h5555_5555, 32'haaaa_aaaa));
		// kinetic momentum equal to energy: zero pz
		send_particle(mk(0, 0, 0, one, 0, 0));
		// energy of minus one: zero path denominator with zero numerator
		send_particle(mk(0, 0, one, 0, 0, 32'he000_0000));
		// energy of minus one and a half: negative path denominator
		send_particle(mk(0, 0, one, one, 0, 32'hd800_0000));
		// transverse momentum above energy: lost
		send_particle(mk(32'h0100_0000, 32'h0200_0000, one, 32'h4000_0000, 0, 0));
		send_particle(mk(0, 0, 0, 0, 32'h1000_0001, 0));
		send_particle(mk(32'h0080_0000, 32'hff80_0000, 32'h0010_0000, 32'h0040_0000,
			32'hffc0_0000, 32'h0020_0000));
		drain();
		// zero strength and rk: kpz of zero, and zero pz with zero strength
		load_regs(0, 0, 32'h1234_5678, 32'h7fff_ffff);
		send_particle(mk(0, 0, 0, one, 0, 0));
		send_particle(mk(one, one, one, 32'h0100_0000, 32'h0100_0000, 0));
		send_particle(mk(0, 0, one, 0, 0, 32'he000_0000));

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: load_regs(mx, mn, mx, 32'hffff_ffff);
				1: load_regs(mn, mx, mn, 0);
				2: load_regs(0, 0, $urandom, $urandom);
				default: load_regs(rnd_span(1 << 29), rnd_span(1 << 28), $urandom,
					$urandom);
			endcase
			no_idle = (ph == 2);
			// the receiver holds off while words keep coming, so input stalls
			if (ph == 3) hold_request = 1'b1;
			for (int i = 0; i < 305; i++) send_particle(random_particle());
		end

		drain();
		repeat (150) @(posedge clk);
		if (chk.errors == 0 && chk.pending_particles.size() == 0) begin
			$display("solenoid_phase_space_map_top_test: PASS");
		end else begin
			$display("solenoid_phase_space_map_top_test: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
